FILE: rtl/core/srmw_pkg.sv
// shared types, constants and helpers for the shifted read mismatch weight core
// no dependencies; imported by every module of the core but srmw_ram

package srmw_pkg;

  localparam int MAX_READ_LEN = 256;
  localparam int ADDR_W       = $clog2(MAX_READ_LEN);
  localparam int LEN_W        = $clog2(MAX_READ_LEN + 1);
  localparam int BASE_W       = 8;
  localparam int OFF_W        = 9;
  localparam int CNT_W        = 9;
  localparam int TERM_W       = LEN_W + 1;
  localparam int WEIGHT_W     = 10;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 1;

  localparam int IN_W         = 48;
  localparam int OUT_W        = 24;

  localparam logic [LEN_W-1:0]    MAX_LEN    = LEN_W'(MAX_READ_LEN);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
  localparam logic [CFG_W-1:0]    CFG_RESET  = CFG_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEN = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_PARENT = 2'd0,
    OP_LOAD_CHILD  = 2'd1,
    OP_COMPUTE     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_WALK,
    ST_FINISH
  } state_e;

  // alignment plan for one compute request
  typedef struct packed {
    logic [ADDR_W-1:0] pstart;
    logic [ADDR_W-1:0] cstart;
    logic [LEN_W-1:0]  overlap;
    logic [TERM_W-1:0] term;
  } plan_t;

  // store read port control driven by the walker
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] p_addr;
    logic [ADDR_W-1:0] c_addr;
  } walk_rd_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = (v > MAX_LEN) ? MAX_LEN : v;
    return r;
  endfunction

endpackage

FILE: rtl/core/srmw_ram.sv
// generic single port ram with registered read data
// no dependencies

module srmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/srmw_align.sv
// alignment planner: start positions, overlap length and shift term
// depends on srmw_pkg

module srmw_align
  import srmw_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [LEN_W-1:0]        parent_len_i,
  input  logic [LEN_W-1:0]        child_len_i,
  input  logic signed [OFF_W-1:0] offset_i,
  input  logic [CFG_W-1:0]        lmax_i,
  output plan_t                   plan_o,
  output logic                    plan_valid_o
);

  logic [LEN_W-1:0]        pl_q, cl_q;
  logic signed [OFF_W-1:0] off_q;
  logic                    calc_q;
  plan_t                   plan_q, plan_d;
  logic                    plan_valid_q;

  logic                    neg, zero;
  logic [OFF_W-1:0]        mag;
  logic [LEN_W-1:0]        base_len, other_len;
  logic signed [LEN_W+1:0] rem, other_s, diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calc_q       <= 1'b0;
      plan_valid_q <= 1'b0;
    end else begin
      calc_q       <= start_i;
      plan_valid_q <= calc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pl_q  <= clamp_len(parent_len_i);
      cl_q  <= clamp_len(child_len_i);
      off_q <= offset_i;
    end
    if (calc_q) begin
      plan_q <= plan_d;
    end
  end

  always_comb begin
    neg       = off_q[OFF_W-1];
    zero      = (off_q == '0);
    mag       = neg ? (~off_q + OFF_W'(1)) : off_q;
    // the read that the shift eats into, and the other one
    base_len  = neg ? cl_q : pl_q;
    other_len = neg ? pl_q : cl_q;
    rem       = $signed({2'b00, base_len}) - $signed({1'b0, 1'b0, mag});
    other_s   = $signed({2'b00, other_len});
    diff      = other_s - rem;

    plan_d.pstart = neg ? '0 : mag[ADDR_W-1:0];
    plan_d.cstart = neg ? mag[ADDR_W-1:0] : '0;

    if (rem <= 0) begin
      plan_d.overlap = '0;
    end else if (other_s < rem) begin
      plan_d.overlap = other_len;
    end else begin
      plan_d.overlap = rem[LEN_W-1:0];
    end

    if (zero) begin
      plan_d.term = '0;
    end else if (pl_q == cl_q) begin
      plan_d.term = TERM_W'(mag);
    end else if (other_s > rem) begin
      // overhang past the end of the shifted read
      plan_d.term = (diff > $signed({2'b00, mag})) ? diff[TERM_W-1:0] : TERM_W'(mag);
    end else begin
      // other read covered: take the longer configured read length
      plan_d.term = TERM_W'(lmax_i);
    end
  end

  assign plan_o       = plan_q;
  assign plan_valid_o = plan_valid_q;

endmodule

FILE: rtl/core/srmw_walk.sv
// base-serial walker: one aligned base pair read and compared per cycle
// depends on srmw_pkg

module srmw_walk
  import srmw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  plan_t             plan_i,
  input  logic [BASE_W-1:0] p_rdata_i,
  input  logic [BASE_W-1:0] c_rdata_i,
  output walk_rd_t          rd_o,
  output logic              done_o,
  output logic [CNT_W-1:0]  mismatch_o
);

  logic [ADDR_W-1:0] p_addr_q, p_addr_d;
  logic [ADDR_W-1:0] c_addr_q, c_addr_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              pend_q, pend_d;
  logic              active_q, active_d;
  logic [CNT_W-1:0]  mm_q, mm_d;
  logic              issue, done;

  assign issue = active_q && (left_q != '0);
  assign done  = active_q && (left_q == '0) && !pend_q;

  always_comb begin
    p_addr_d = p_addr_q;
    c_addr_d = c_addr_q;
    left_d   = left_q;
    pend_d   = issue;
    active_d = active_q && !done;
    mm_d     = mm_q;
    if (pend_q && (p_rdata_i != c_rdata_i)) begin
      mm_d = mm_q + CNT_W'(1);
    end
    if (issue) begin
      p_addr_d = p_addr_q + ADDR_W'(1);
      c_addr_d = c_addr_q + ADDR_W'(1);
      left_d   = left_q - LEN_W'(1);
    end
    if (start_i) begin
      p_addr_d = plan_i.pstart;
      c_addr_d = plan_i.cstart;
      left_d   = plan_i.overlap;
      pend_d   = 1'b0;
      active_d = 1'b1;
      mm_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      pend_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      left_q   <= left_d;
      pend_q   <= pend_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_addr_q <= p_addr_d;
    c_addr_q <= c_addr_d;
    mm_q     <= mm_d;
  end

  assign rd_o.rd_en  = issue;
  assign rd_o.p_addr = p_addr_q;
  assign rd_o.c_addr = c_addr_q;
  assign done_o      = done;
  assign mismatch_o  = mm_q;

endmodule

FILE: rtl/core/shifted_read_mismatch_weight_core.sv
// top level of the shifted read mismatch weight core
// depends on srmw_pkg, srmw_ram, srmw_align and srmw_walk
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------------
//  s_axis   | in        | tvalid / tready       | tdata: load or compute request
//  m_axis   | out       | tvalid / tready       | tdata: weight and mismatch count
//  cfg      | in        | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
//  a load request is written into its store at the accept edge
//  a compute request passes through the align, walk and finish states; the walker
//  compares one base pair per cycle through one port per store
//  reset clears control and the length registers; the stores are not cleared
//  a waiting result does not block loads; a second compute waits in its finish
//  state until the output register is free

module shifted_read_mismatch_weight_core
  import srmw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // opcode[1:0], base_index[9:2], base_char[17:10], parent_length[26:18],
  // child_length[35:27], offset[44:36], zero[47:45]
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // weight[9:0], mismatch_count[18:10], zero[23:19]
  output logic [OUT_W-1:0]     m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // request fields
  logic [1:0]              in_opcode;
  logic [ADDR_W-1:0]       in_index;
  logic [BASE_W-1:0]       in_char;
  logic [LEN_W-1:0]        in_plen;
  logic [LEN_W-1:0]        in_clen;
  logic signed [OFF_W-1:0] in_offset;

  assign in_opcode = s_axis_tdata[1:0];
  assign in_index  = s_axis_tdata[9:2];
  assign in_char   = s_axis_tdata[17:10];
  assign in_plen   = s_axis_tdata[26:18];
  assign in_clen   = s_axis_tdata[35:27];
  assign in_offset = s_axis_tdata[44:36];

  state_e state_q, state_d;

  logic              accept;
  logic              p_we, c_we, start_compute;
  logic [CFG_W-1:0]  first_len_q, second_len_q, lmax;
  plan_t             plan;
  logic              plan_valid;
  walk_rd_t          walk_rd;
  logic              walk_done;
  logic [CNT_W-1:0]  walk_mm;
  logic [BASE_W-1:0] p_rdata, c_rdata;
  logic [ADDR_W-1:0] p_addr, c_addr;

  logic                out_valid_q, out_valid_d;
  logic [WEIGHT_W-1:0] out_weight_q, out_weight_d;
  logic [CNT_W-1:0]    out_mm_q;
  logic                out_load;
  logic [CNT_W+2:0]    weight_sum;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= CFG_RESET;
      second_len_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_LEN:  first_len_q  <= cfg_data_i;
        CFG_SECOND_LEN: second_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lmax = (first_len_q > second_len_q) ? first_len_q : second_len_q;

  // ---------------------------------------------------------------- request decode
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    p_we          = 1'b0;
    c_we          = 1'b0;
    start_compute = 1'b0;
    unique case (in_opcode)
      OP_LOAD_PARENT: p_we          = accept;
      OP_LOAD_CHILD:  c_we          = accept;
      OP_COMPUTE:     start_compute = accept;
      default: ;  // unused opcode is dropped
    endcase
  end

  // ---------------------------------------------------------------- stores
  // loads only land in idle, reads only happen in walk, so one port is enough
  assign p_addr = p_we ? in_index : walk_rd.p_addr;
  assign c_addr = c_we ? in_index : walk_rd.c_addr;

  srmw_ram #(
    .WIDTH (BASE_W),
    .DEPTH (MAX_READ_LEN)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .re_i    (walk_rd.rd_en),
    .addr_i  (p_addr),
    .wdata_i (in_char),
    .rdata_o (p_rdata)
  );

  srmw_ram #(
    .WIDTH (BASE_W),
    .DEPTH (MAX_READ_LEN)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .re_i    (walk_rd.rd_en),
    .addr_i  (c_addr),
    .wdata_i (in_char),
    .rdata_o (c_rdata)
  );

  // ---------------------------------------------------------------- planner and walker
  srmw_align u_align (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_compute),
    .parent_len_i (in_plen),
    .child_len_i  (in_clen),
    .offset_i     (in_offset),
    .lmax_i       (lmax),
    .plan_o       (plan),
    .plan_valid_o (plan_valid)
  );

  srmw_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (plan_valid),
    .plan_i     (plan),
    .p_rdata_i  (p_rdata),
    .c_rdata_i  (c_rdata),
    .rd_o       (walk_rd),
    .done_o     (walk_done),
    .mismatch_o (walk_mm)
  );

  // ---------------------------------------------------------------- control fsm
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_compute) state_d = ST_ALIGN;
      ST_ALIGN:  state_d = ST_WALK;
      ST_WALK:   if (walk_done) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- result register
  // weight = 3 * count + shift term, saturated
  assign weight_sum   = ({2'b00, walk_mm, 1'b0} + {3'b000, walk_mm})
                        + (CNT_W+3)'(plan.term);
  assign out_weight_d = (weight_sum > (CNT_W+3)'(WEIGHT_MAX)) ? WEIGHT_MAX
                                                              : weight_sum[WEIGHT_W-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (out_load)      out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_weight_q <= out_weight_d;
      out_mm_q     <= walk_mm;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_W - WEIGHT_W - CNT_W)'(0), out_mm_q, out_weight_q};

`ifndef SYNTHESIS
  // the count can never pass the number of compared pairs
  a_mm_within_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |-> (walk_mm <= CNT_W'(plan.overlap)))
    else $error("mismatch count exceeds overlap");

  // a store write must never collide with a walker read
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((p_we || c_we) && walk_rd.rd_en))
    else $error("store write during walk read");

  a_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |-> (state_q == ST_WALK))
    else $error("walker finished outside walk state");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised without a finished compute");
`endif

endmodule
